/* sv/cewa_pkg.sv */
// Shared constants and types for the cotangent edge weight accumulator.
// No dependencies; imported by cotan_edge_weight_accumulator.
package cewa_pkg;

  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FIELD_W        = 16;  // width of one coordinate field
  localparam int unsigned COT_W          = 32;
  localparam int unsigned AREA_W         = 40;
  localparam int unsigned LEN_W          = 18;
  localparam int unsigned FRAC_SHIFT     = 32;  // dot^2 scaled by 2^32 before the divide
  localparam int unsigned IN_DATA_W      = 9 * FIELD_W;
  localparam int unsigned OUT_DATA_W     = 96;  // 32 + 40 + 18 bits, padded to bytes

  localparam logic [COT_W:0]    COT_NEG_LIM = 33'h0_8000_0000;
  localparam logic [COT_W:0]    COT_POS_LIM = 33'h0_7FFF_FFFF;
  localparam logic [AREA_W-1:0] AREA_MAX    = '1;
  localparam logic [LEN_W-1:0]  LEN_MAX     = '1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_EMIT = 6'b100000
  } state_e;

  // multiply steps of one triangle, then of the edge length
  typedef enum logic [3:0] {
    OP_DOT0, OP_DOT1, OP_DOT2,
    OP_CRX0, OP_CRX1, OP_SQX,
    OP_CRY0, OP_CRY1, OP_SQY,
    OP_CRZ0, OP_CRZ1, OP_SQZ,
    OP_DSQ,
    OP_LEN0, OP_LEN1, OP_LEN2
  } op_e;

  typedef enum logic [1:0] {
    RT_COT,
    RT_AREA,
    RT_LEN
  } root_e;

endpackage

/* sv/cotan_edge_weight_accumulator.sv */
// Cotangent-Laplacian edge weight accumulator: sequencer, bit-serial multiplier,
// restoring divider and digit-by-digit square root. Depends on cewa_pkg.
// Per triangle: 13 multiplies, then a divide and two roots; a degenerate triangle skips
// the divide and roots. A last triangle adds 3 multiplies, one root and an output
// step. One triangle at a time.
// Reset (rst_ni low, async) clears the sums, the degenerate flag and the output valid.
module cotan_edge_weight_accumulator
  import cewa_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // end_a_x, end_a_y, end_a_z, end_b_x, end_b_y, end_b_z, apex_x, apex_y, apex_z
  // (16 bits each, lowest first)
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tlast,   // last_face
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // cotan_sum [31:0], area_sum [71:32], edge_length [89:72], zero pad [95:90]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  output logic                  m_axis_tuser,   // degenerate
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready
);

  localparam int unsigned C   = COORD_BITS;
  localparam int unsigned VW  = C + 1;          // coordinate difference
  localparam int unsigned OW  = 2 * C + 3;      // signed dot / cross value
  localparam int unsigned MW  = 2 * C + 2;      // multiplier operand magnitude
  localparam int unsigned PW  = 4 * C + 4;      // product, S, dot^2
  localparam int unsigned DW  = PW + FRAC_SHIFT; // dividend / root input
  localparam int unsigned RW  = DW / 2;         // root width
  localparam int unsigned DCW = $clog2(DW);
  localparam int unsigned SCW = $clog2(RW);

  function automatic logic signed [C-1:0] crd(input logic [FIELD_W-1:0] raw);
    crd = C'(raw);
  endfunction

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  op_e    op_q, op_d;
  root_e  rsel_q, rsel_d;
  logic   last_q, last_d;

  logic signed [VW-1:0] v1_q [3], v1_d [3];
  logic signed [VW-1:0] v2_q [3], v2_d [3];
  logic signed [VW-1:0] dl_q [3], dl_d [3];
  logic signed [OW-1:0] dot_q, dot_d, cr_q, cr_d;
  logic [PW-1:0]        sq_q, sq_d;            // S, later the edge length sum

  logic [PW-1:0]  ma_q, ma_d, prod_q, prod_d;
  logic [MW-1:0]  mb_q, mb_d;
  logic           mneg_q, mneg_d;

  logic [DW-1:0]  dv_q, dv_d;                  // dividend, shifts into quotient
  logic [PW:0]    rem_q, rem_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;

  logic [DW-1:0]  sx_q, sx_d;
  logic [RW-1:0]  rt_q, rt_d;
  logic [RW:0]    sr_q, sr_d;
  logic [SCW-1:0] scnt_q, scnt_d;

  logic signed [COT_W:0] cterm_q, cterm_d;
  logic [LEN_W-1:0]      len_q, len_d;

  logic signed [COT_W-1:0] cot_acc_q, cot_acc_d;
  logic [AREA_W-1:0]       area_acc_q, area_acc_d;
  logic                    deg_q, deg_d;

  logic                  ovalid_q, ovalid_d;
  logic [OUT_DATA_W-1:0] odata_q, odata_d;
  logic                  odeg_q, odeg_d;

  // ---------------------------------------------------------------------------
  // Operand select for the multiply step in op_q
  // ---------------------------------------------------------------------------
  logic signed [OW-1:0] opa, opb, absa, absb;

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (op_q)
      OP_DOT0: begin opa = OW'(v1_q[0]); opb = OW'(v2_q[0]); end
      OP_DOT1: begin opa = OW'(v1_q[1]); opb = OW'(v2_q[1]); end
      OP_DOT2: begin opa = OW'(v1_q[2]); opb = OW'(v2_q[2]); end
      OP_CRX0: begin opa = OW'(v1_q[1]); opb = OW'(v2_q[2]); end
      OP_CRX1: begin opa = OW'(v1_q[2]); opb = OW'(v2_q[1]); end
      OP_CRY0: begin opa = OW'(v1_q[2]); opb = OW'(v2_q[0]); end
      OP_CRY1: begin opa = OW'(v1_q[0]); opb = OW'(v2_q[2]); end
      OP_CRZ0: begin opa = OW'(v1_q[0]); opb = OW'(v2_q[1]); end
      OP_CRZ1: begin opa = OW'(v1_q[1]); opb = OW'(v2_q[0]); end
      OP_SQX, OP_SQY, OP_SQZ: begin opa = cr_q; opb = cr_q; end
      OP_DSQ:  begin opa = dot_q; opb = dot_q; end
      OP_LEN0: begin opa = OW'(dl_q[0]); opb = OW'(dl_q[0]); end
      OP_LEN1: begin opa = OW'(dl_q[1]); opb = OW'(dl_q[1]); end
      OP_LEN2: begin opa = OW'(dl_q[2]); opb = OW'(dl_q[2]); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign absa = opa[OW-1] ? -opa : opa;
  assign absb = opb[OW-1] ? -opb : opb;

  // signed product of the finished multiply
  logic signed [PW:0]   prod_s;
  logic signed [OW-1:0] prod_o;
  assign prod_s = mneg_q ? -$signed({1'b0, prod_q}) : $signed({1'b0, prod_q});
  assign prod_o = OW'(prod_s);

  // ---------------------------------------------------------------------------
  // Divider and root steps
  // ---------------------------------------------------------------------------
  logic [PW:0]   div_r2;
  logic          div_ge;
  assign div_r2 = {rem_q[PW-1:0], dv_q[DW-1]};
  assign div_ge = div_r2 >= {1'b0, sq_q};

  logic [RW+1:0] rt_r2, rt_trial;
  logic          rt_ge;
  assign rt_r2    = {sr_q[RW-1:0], sx_q[DW-1 -: 2]};
  assign rt_trial = {rt_q, 2'b01};
  assign rt_ge    = rt_r2 >= rt_trial;

  logic [RW-1:0] root_nx;
  assign root_nx = {rt_q[RW-2:0], rt_ge};

  // saturated terms from the finished root
  logic [COT_W:0]        cot_mag;
  logic signed [COT_W:0] cot_term;
  logic [AREA_W-1:0]     area_term;
  logic [LEN_W-1:0]      len_term;
  always_comb begin
    if (dot_q[OW-1]) begin
      cot_mag  = (root_nx > RW'(COT_NEG_LIM)) ? COT_NEG_LIM : (COT_W+1)'(root_nx);
      cot_term = -$signed(cot_mag);
    end else begin
      cot_mag  = (root_nx > RW'(COT_POS_LIM)) ? COT_POS_LIM : (COT_W+1)'(root_nx);
      cot_term = $signed(cot_mag);
    end
    area_term = (|root_nx[RW-1:AREA_W]) ? AREA_MAX : root_nx[AREA_W-1:0];
    len_term  = (|root_nx[RW-1:LEN_W])  ? LEN_MAX  : root_nx[LEN_W-1:0];
  end

  // saturating accumulation of one triangle
  logic signed [COT_W+1:0] cot_sum;
  logic [AREA_W:0]         area_sum;
  logic signed [COT_W-1:0] cot_sat;
  logic [AREA_W-1:0]       area_sat;
  assign cot_sum  = (COT_W+2)'(cot_acc_q) + (COT_W+2)'(cterm_q);
  assign area_sum = {1'b0, area_acc_q} + {1'b0, area_term};
  always_comb begin
    if (cot_sum > (COT_W+2)'($signed(COT_POS_LIM))) begin
      cot_sat = COT_W'($signed(COT_POS_LIM));
    end else if (cot_sum < -(COT_W+2)'($signed(COT_NEG_LIM))) begin
      cot_sat = COT_W'(-$signed(COT_NEG_LIM));
    end else begin
      cot_sat = COT_W'(cot_sum);
    end
    area_sat = area_sum[AREA_W] ? AREA_MAX : area_sum[AREA_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    rsel_d     = rsel_q;
    last_d     = last_q;
    v1_d       = v1_q;
    v2_d       = v2_q;
    dl_d       = dl_q;
    dot_d      = dot_q;
    cr_d       = cr_q;
    sq_d       = sq_q;
    ma_d       = ma_q;
    mb_d       = mb_q;
    prod_d     = prod_q;
    mneg_d     = mneg_q;
    dv_d       = dv_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    sx_d       = sx_q;
    rt_d       = rt_q;
    sr_d       = sr_q;
    scnt_d     = scnt_q;
    cterm_d    = cterm_q;
    len_d      = len_q;
    cot_acc_d  = cot_acc_q;
    area_acc_d = area_acc_q;
    deg_d      = deg_q;
    ovalid_d   = ovalid_q;
    odata_d    = odata_q;
    odeg_d     = odeg_q;

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            v1_d[i] = VW'(crd(s_axis_tdata[(3+i)*FIELD_W +: FIELD_W]))
                    - VW'(crd(s_axis_tdata[(6+i)*FIELD_W +: FIELD_W]));
            v2_d[i] = VW'(crd(s_axis_tdata[i*FIELD_W +: FIELD_W]))
                    - VW'(crd(s_axis_tdata[(6+i)*FIELD_W +: FIELD_W]));
            dl_d[i] = VW'(crd(s_axis_tdata[(3+i)*FIELD_W +: FIELD_W]))
                    - VW'(crd(s_axis_tdata[i*FIELD_W +: FIELD_W]));
          end
          last_d  = s_axis_tlast;
          op_d    = OP_DOT0;
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        // magnitude is unsigned: zero-extend into the shifter
        ma_d    = PW'($unsigned(MW'(absa)));
        mb_d    = MW'(absb);
        mneg_d  = opa[OW-1] ^ opb[OW-1];
        prod_d  = '0;
        state_d = ST_MUL;
      end

      ST_MUL: begin
        if (mb_q != '0) begin
          // one multiplier bit per cycle
          prod_d = prod_q + (mb_q[0] ? ma_q : '0);
          ma_d   = {ma_q[PW-2:0], 1'b0};
          mb_d   = {1'b0, mb_q[MW-1:1]};
        end else begin
          state_d = ST_LOAD;
          op_d    = op_e'(op_q + 1'b1);
          unique case (op_q)
            OP_DOT0: dot_d = prod_o;
            OP_DOT1, OP_DOT2: dot_d = dot_q + prod_o;
            OP_CRX0, OP_CRY0, OP_CRZ0: cr_d = prod_o;
            OP_CRX1, OP_CRY1, OP_CRZ1: cr_d = cr_q - prod_o;
            OP_SQX, OP_LEN0: sq_d = prod_q;
            OP_SQY, OP_SQZ, OP_LEN1: sq_d = sq_q + prod_q;
            OP_DSQ: begin
              if (sq_q == '0) begin
                // zero cross length: no terms, flag only
                deg_d   = 1'b1;
                op_d    = OP_LEN0;
                state_d = last_q ? ST_LOAD : ST_IDLE;
              end else begin
                dv_d    = {prod_q, FRAC_SHIFT'(0)};
                rem_d   = '0;
                dcnt_d  = '0;
                state_d = ST_DIV;
              end
            end
            OP_LEN2: begin
              sq_d    = sq_q + prod_q;
              sx_d    = DW'(sq_q + prod_q);
              rt_d    = '0;
              sr_d    = '0;
              scnt_d  = '0;
              rsel_d  = RT_LEN;
              state_d = ST_SQRT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_DIV: begin
        // restoring divide, one quotient bit per cycle
        rem_d  = div_ge ? (div_r2 - {1'b0, sq_q}) : div_r2;
        dv_d   = {dv_q[DW-2:0], div_ge};
        dcnt_d = dcnt_q + 1'b1;
        if (dcnt_q == DCW'(DW - 1)) begin
          sx_d    = {dv_q[DW-2:0], div_ge};
          rt_d    = '0;
          sr_d    = '0;
          scnt_d  = '0;
          rsel_d  = RT_COT;
          state_d = ST_SQRT;
        end
      end

      ST_SQRT: begin
        // two radicand bits, one root bit per cycle
        sr_d   = rt_ge ? (RW+1)'(rt_r2 - rt_trial) : (RW+1)'(rt_r2);
        rt_d   = root_nx;
        sx_d   = {sx_q[DW-3:0], 2'b00};
        scnt_d = scnt_q + 1'b1;
        if (scnt_q == SCW'(RW - 1)) begin
          unique case (rsel_q)
            RT_COT: begin
              cterm_d = cot_term;
              sx_d    = DW'(sq_q >> 2);
              rt_d    = '0;
              sr_d    = '0;
              scnt_d  = '0;
              rsel_d  = RT_AREA;
            end
            RT_AREA: begin
              cot_acc_d  = cot_sat;
              area_acc_d = area_sat;
              op_d       = OP_LEN0;
              state_d    = last_q ? ST_LOAD : ST_IDLE;
            end
            RT_LEN: begin
              len_d   = len_term;
              state_d = ST_EMIT;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end

      ST_EMIT: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d   = 1'b1;
          odata_d    = {6'b0, len_q, area_acc_q, cot_acc_q};
          odeg_d     = deg_q;
          cot_acc_d  = '0;
          area_acc_d = '0;
          deg_d      = 1'b0;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_DOT0;
      rsel_q     <= RT_COT;
      last_q     <= 1'b0;
      dcnt_q     <= '0;
      scnt_q     <= '0;
      cot_acc_q  <= '0;
      area_acc_q <= '0;
      deg_q      <= 1'b0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      rsel_q     <= rsel_d;
      last_q     <= last_d;
      dcnt_q     <= dcnt_d;
      scnt_q     <= scnt_d;
      cot_acc_q  <= cot_acc_d;
      area_acc_q <= area_acc_d;
      deg_q      <= deg_d;
      ovalid_q   <= ovalid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    v1_q    <= v1_d;
    v2_q    <= v2_d;
    dl_q    <= dl_d;
    dot_q   <= dot_d;
    cr_q    <= cr_d;
    sq_q    <= sq_d;
    ma_q    <= ma_d;
    mb_q    <= mb_d;
    prod_q  <= prod_d;
    mneg_q  <= mneg_d;
    dv_q    <= dv_d;
    rem_q   <= rem_d;
    sx_q    <= sx_d;
    rt_q    <= rt_d;
    sr_q    <= sr_d;
    cterm_q <= cterm_d;
    len_q   <= len_d;
    odata_q <= odata_d;
    odeg_q  <= odeg_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = odeg_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (sq_q != '0))
    else $error("divide by zero cross length");

  a_mul_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL) && $past(state_q == ST_MUL) |-> (mb_q <= $past(mb_q)))
    else $error("multiplier operand grew");

  a_clear_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && (state_d == ST_IDLE) |=> (cot_acc_q == '0) && !deg_q)
    else $error("sums not cleared after emit");

endmodule
